// ----- sv/pvdt_pkg.sv -----
`default_nettype none

package pvdt_pkg;

    localparam int COORD_W  = 32;
    localparam int REG_W    = 31;
    localparam int IDX_W    = 10;
    localparam int CFG_AW   = 3;
    localparam int FRAC_BITS = 24;

    localparam logic [REG_W-1:0] PERIOD_RESET = REG_W'(64'd1 << FRAC_BITS);
    localparam logic [REG_W-1:0] TOL_RESET    =
        REG_W'(((64'd1 << FRAC_BITS) + 64'd50000) / 64'd100000);

    localparam logic [CFG_AW-1:0] CFG_PERIOD_X  = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] CFG_PERIOD_Y  = CFG_AW'(1);
    localparam logic [CFG_AW-1:0] CFG_PERIOD_Z  = CFG_AW'(2);
    localparam logic [CFG_AW-1:0] CFG_MATCH_TOL = CFG_AW'(3);

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] unique_index;
        logic             is_new;
        logic             table_overflow;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vertex;

    typedef struct packed {
        logic [REG_W-1:0] period_x;
        logic [REG_W-1:0] period_y;
        logic [REG_W-1:0] period_z;
        logic [REG_W-1:0] match_tolerance;
    } t_cfg;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_back_state;

endpackage

`default_nettype wire

// ----- sv/pvdt_ram.sv -----
`default_nettype none

module pvdt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/pvdt_front.sv -----
`default_nettype none

module pvdt_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pvdt_pkg::t_cfg    i_cfg,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire pvdt_pkg::t_in_item i_in_item,
    output logic                   o_push_valid,
    input  wire logic              i_push_ready,
    output pvdt_pkg::t_vertex      o_push_vertex
);

    logic              r_valid;
    logic              n_valid;
    pvdt_pkg::t_vertex r_vert;
    pvdt_pkg::t_vertex n_vert;

    function automatic logic [pvdt_pkg::COORD_W-1:0] fold_axis(
        input logic [pvdt_pkg::COORD_W-1:0] c,
        input logic [pvdt_pkg::REG_W-1:0]   p
    );
        logic [pvdt_pkg::COORD_W:0] ce;
        logic [pvdt_pkg::COORD_W:0] pe;
        logic [pvdt_pkg::COORD_W:0] sum;
        logic [pvdt_pkg::COORD_W:0] dif;
        begin
            ce  = {c[pvdt_pkg::COORD_W-1], c};
            pe  = {{(pvdt_pkg::COORD_W+1-pvdt_pkg::REG_W){1'b0}}, p};
            sum = ce + pe;
            dif = ce - pe;
            if (c[pvdt_pkg::COORD_W-1]) begin
                fold_axis = sum[pvdt_pkg::COORD_W-1:0];
            end else if ($signed(ce) > $signed(pe)) begin
                fold_axis = dif[pvdt_pkg::COORD_W-1:0];
            end else begin
                fold_axis = c;
            end
        end
    endfunction

    assign o_ready = !r_valid || i_push_ready;

    always_comb begin
        n_valid = r_valid;
        n_vert  = r_vert;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid  = 1'b1;
            n_vert.x = fold_axis(i_in_item.coord_x, i_cfg.period_x);
            n_vert.y = fold_axis(i_in_item.coord_y, i_cfg.period_y);
            n_vert.z = fold_axis(i_in_item.coord_z, i_cfg.period_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vert <= n_vert;
    end

    assign o_push_valid  = r_valid;
    assign o_push_vertex = r_vert;

endmodule

`default_nettype wire

// ----- sv/pvdt_queue.sv -----
`default_nettype none

module pvdt_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push_valid,
    output logic                   o_push_ready,
    input  wire pvdt_pkg::t_vertex i_push_vertex,
    output logic                   o_pop_valid,
    input  wire logic              i_pop_ready,
    output pvdt_pkg::t_vertex      o_pop_vertex
);

    pvdt_pkg::t_vertex r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_fill;
    logic              n_wr_ptr;
    logic              n_rd_ptr;
    logic [1:0]        n_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != 2'd2);
    assign o_pop_valid  = (r_fill != 2'd0);
    assign o_pop_vertex = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? !r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + 2'd1;
        end else if (pop && !push) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_vertex;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pvdt_back.sv -----
`default_nettype none

module pvdt_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pvdt_pkg::t_cfg    i_cfg,
    input  wire logic              i_pop_valid,
    output logic                   o_pop_ready,
    input  wire pvdt_pkg::t_vertex i_pop_vertex,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output pvdt_pkg::t_out_item    o_out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int VW = 3 * pvdt_pkg::COORD_W;
    localparam int DW = pvdt_pkg::COORD_W + 1;
    localparam logic [AW:0] DEPTH_C = (AW+1)'(TABLE_DEPTH);

    pvdt_pkg::t_back_state r_state;
    pvdt_pkg::t_back_state n_state;
    pvdt_pkg::t_vertex     r_vert;
    pvdt_pkg::t_vertex     n_vert;
    logic [AW:0]           r_rd_idx;
    logic [AW:0]           n_rd_idx;
    logic                  r_cmp_valid;
    logic                  n_cmp_valid;
    logic [AW-1:0]         r_cmp_idx;
    logic [AW-1:0]         n_cmp_idx;
    logic [AW:0]           r_count;
    logic [AW:0]           n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    pvdt_pkg::t_out_item   r_out;
    pvdt_pkg::t_out_item   n_out;

    logic                  ram_we;
    logic [VW-1:0]         ram_rdata;
    pvdt_pkg::t_vertex     rd_vert;
    logic [DW-1:0]         tol_e;
    logic [DW-1:0]         neg_tol;
    logic [DW-1:0]         dx;
    logic [DW-1:0]         dy;
    logic [DW-1:0]         dz;
    logic                  hit;
    logic                  issue;

    function automatic logic [pvdt_pkg::IDX_W-1:0] to_index(input logic [AW-1:0] idx);
        logic [AW+pvdt_pkg::IDX_W-1:0] wide;
        begin
            wide     = {{pvdt_pkg::IDX_W{1'b0}}, idx};
            to_index = wide[pvdt_pkg::IDX_W-1:0];
        end
    endfunction

    pvdt_ram #(
        .WIDTH (VW),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_vert),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_vert = ram_rdata;
    assign tol_e   = {{(DW-pvdt_pkg::REG_W){1'b0}}, i_cfg.match_tolerance};
    assign neg_tol = DW'(0) - tol_e;
    assign dx      = {rd_vert.x[pvdt_pkg::COORD_W-1], rd_vert.x}
                   - {r_vert.x[pvdt_pkg::COORD_W-1], r_vert.x};
    assign dy      = {rd_vert.y[pvdt_pkg::COORD_W-1], rd_vert.y}
                   - {r_vert.y[pvdt_pkg::COORD_W-1], r_vert.y};
    assign dz      = {rd_vert.z[pvdt_pkg::COORD_W-1], rd_vert.z}
                   - {r_vert.z[pvdt_pkg::COORD_W-1], r_vert.z};
    assign hit     = ($signed(dx) < $signed(tol_e)) && ($signed(dx) > $signed(neg_tol))
                  && ($signed(dy) < $signed(tol_e)) && ($signed(dy) > $signed(neg_tol))
                  && ($signed(dz) < $signed(tol_e)) && ($signed(dz) > $signed(neg_tol));
    assign issue   = (r_rd_idx < r_count);

    assign o_pop_ready = (r_state == pvdt_pkg::BK_IDLE) && !r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_vert      = r_vert;
        n_rd_idx    = r_rd_idx;
        n_cmp_valid = r_cmp_valid;
        n_cmp_idx   = r_cmp_idx;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            pvdt_pkg::BK_IDLE: begin
                n_cmp_valid = 1'b0;
                if (i_pop_valid && !r_out_valid) begin
                    n_vert   = i_pop_vertex;
                    n_rd_idx = '0;
                    n_state  = pvdt_pkg::BK_SCAN;
                end
            end
            pvdt_pkg::BK_SCAN: begin
                n_cmp_valid = issue;
                n_cmp_idx   = r_rd_idx[AW-1:0];
                if (issue) begin
                    n_rd_idx = r_rd_idx + (AW+1)'(1);
                end
                if (r_cmp_valid && hit) begin
                    n_out.unique_index   = to_index(r_cmp_idx);
                    n_out.is_new         = 1'b0;
                    n_out.table_overflow = 1'b0;
                    n_out_valid          = 1'b1;
                    n_cmp_valid          = 1'b0;
                    n_state              = pvdt_pkg::BK_IDLE;
                end else if (!r_cmp_valid && !issue) begin
                    if (r_count == DEPTH_C) begin
                        n_out.unique_index   = '0;
                        n_out.is_new         = 1'b0;
                        n_out.table_overflow = 1'b1;
                    end else begin
                        ram_we               = 1'b1;
                        n_count              = r_count + (AW+1)'(1);
                        n_out.unique_index   = to_index(r_count[AW-1:0]);
                        n_out.is_new         = 1'b1;
                        n_out.table_overflow = 1'b0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = pvdt_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = pvdt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pvdt_pkg::BK_IDLE;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_cmp_valid <= n_cmp_valid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vert    <= n_vert;
        r_cmp_idx <= n_cmp_idx;
        r_out     <= n_out;
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond table depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < DEPTH_C) && (r_state == pvdt_pkg::BK_SCAN))
        else $error("store written without room");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_count == $past(r_count) + (AW+1)'(1)) && r_out_valid
                   && r_out.is_new)
        else $error("append did not advance count");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.is_new && r_out.table_overflow))
        else $error("result both new and overflow");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvdt_pkg::BK_SCAN) |-> (r_rd_idx <= r_count) && !r_out_valid)
        else $error("scan index past entry count");

endmodule

`default_nettype wire

// ----- sv/periodic_vertex_dedup_table_core.sv -----
// Welds 3-D vertices in a periodic box. Each input item is one signed fixed-point
// vertex; each axis is folded once into the box, then the vertex is searched in
// the table of stored vertices in insertion order (first entry with every axis
// difference strictly below match_tolerance wins) or appended if none matches.
// Exactly one result item per input item: the entry index, an is_new flag, or
// table_overflow when the table is full and nothing matched. The registered fold
// stage hands the item through a two-entry queue to the search engine, so new
// items are taken while a search runs. A search reads the stored entries
// through the single read port of the vertex memory, which delivers one
// stored vertex per cycle. The table is empty after reset and needs no
// clearing pass. Configuration is written through the cfg port, which is
// always ready, and should only change while the block is idle.
`default_nettype none

module periodic_vertex_dedup_table_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire pvdt_pkg::t_in_item            i_in_item,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output pvdt_pkg::t_out_item                o_out_item,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pvdt_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [pvdt_pkg::REG_W-1:0]    i_cfg_data
);

    pvdt_pkg::t_cfg    r_cfg;
    pvdt_pkg::t_cfg    n_cfg;
    logic              push_valid;
    logic              push_ready;
    pvdt_pkg::t_vertex push_vertex;
    logic              pop_valid;
    logic              pop_ready;
    pvdt_pkg::t_vertex pop_vertex;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_addr)
                pvdt_pkg::CFG_PERIOD_X:  n_cfg.period_x        = i_cfg_data;
                pvdt_pkg::CFG_PERIOD_Y:  n_cfg.period_y        = i_cfg_data;
                pvdt_pkg::CFG_PERIOD_Z:  n_cfg.period_z        = i_cfg_data;
                pvdt_pkg::CFG_MATCH_TOL: n_cfg.match_tolerance = i_cfg_data;
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_x        <= pvdt_pkg::PERIOD_RESET;
            r_cfg.period_y        <= pvdt_pkg::PERIOD_RESET;
            r_cfg.period_z        <= pvdt_pkg::PERIOD_RESET;
            r_cfg.match_tolerance <= pvdt_pkg::TOL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    pvdt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_item     (i_in_item),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_vertex (push_vertex)
    );

    pvdt_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push_valid  (push_valid),
        .o_push_ready  (push_ready),
        .i_push_vertex (push_vertex),
        .o_pop_valid   (pop_valid),
        .i_pop_ready   (pop_ready),
        .o_pop_vertex  (pop_vertex)
    );

    pvdt_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_vertex (pop_vertex),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_item   (o_out_item)
    );

endmodule

`default_nettype wire

// ----- sim/tb_periodic_vertex_dedup_table_core.sv -----
module tb_periodic_vertex_dedup_table_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     TABLE_SIZE     = 1024;
    localparam int     COORD_W        = pvdt_pkg::COORD_W;
    localparam int     REG_W          = pvdt_pkg::REG_W;
    localparam int     IDX_W          = pvdt_pkg::IDX_W;
    localparam int     CFG_AW         = pvdt_pkg::CFG_AW;
    localparam int     PRESSURE_HOLD  = 3000;
    localparam int     QUIET_LIMIT    = 20000;
    localparam int     SETTLE_CYCLES  = 8;
    localparam int     PENDING_MAX    = 4;
    localparam longint COORD_MAX      = 64'sd2147483647;
    localparam longint COORD_MIN      = -64'sd2147483648;
    localparam logic [CFG_AW-1:0] CFG_SPARE = CFG_AW'(5);

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    pvdt_pkg::t_in_item  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    pvdt_pkg::t_out_item out_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [REG_W-1:0]    cfg_data = '0;

    pvdt_pkg::t_in_item  pending_vertices[$];
    pvdt_pkg::t_out_item expected_welds[$];
    pvdt_pkg::t_vertex   welded_table[$];
    pvdt_pkg::t_cfg      shadow_cfg = '{period_x: pvdt_pkg::PERIOD_RESET,
                                        period_y: pvdt_pkg::PERIOD_RESET,
                                        period_z: pvdt_pkg::PERIOD_RESET,
                                        match_tolerance: pvdt_pkg::TOL_RESET};

    int items_queued = 0;
    int items_checked = 0;
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int pressure_requests = 0;
    int pressure_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    periodic_vertex_dedup_table_core #(
        .TABLE_DEPTH (TABLE_SIZE)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_in_item   (in_item),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic signed [COORD_W-1:0] fold_coord(logic signed [COORD_W-1:0] c,
                                                            logic [REG_W-1:0] period);
        longint v;
        longint p;
        v = c;
        p = period;
        if (v < 0)
            v += p;
        if (v > p)
            v -= p;
        return v[COORD_W-1:0];
    endfunction

    function automatic bit close_axis(logic signed [COORD_W-1:0] a,
                                      logic signed [COORD_W-1:0] b);
        longint d;
        longint tol;
        d = longint'(a) - longint'(b);
        tol = shadow_cfg.match_tolerance;
        if (d < 0)
            d = -d;
        return d < tol;
    endfunction

    function automatic pvdt_pkg::t_out_item weld_vertex(pvdt_pkg::t_in_item vtx);
        pvdt_pkg::t_vertex   v;
        pvdt_pkg::t_out_item r;
        v.x = fold_coord(vtx.coord_x, shadow_cfg.period_x);
        v.y = fold_coord(vtx.coord_y, shadow_cfg.period_y);
        v.z = fold_coord(vtx.coord_z, shadow_cfg.period_z);
        r = '0;
        foreach (welded_table[i]) begin
            if (close_axis(welded_table[i].x, v.x) && close_axis(welded_table[i].y, v.y) &&
                close_axis(welded_table[i].z, v.z)) begin
                r.unique_index = IDX_W'(i);
                return r;
            end
        end
        if (welded_table.size() >= TABLE_SIZE) begin
            r.table_overflow = 1'b1;
            return r;
        end
        r.unique_index = IDX_W'(welded_table.size());
        r.is_new = 1'b1;
        welded_table.insert(welded_table.size(), v);
        return r;
    endfunction

    // a point near a stored vertex, sometimes shifted one period out of the box
    function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] base,
                                                            logic [REG_W-1:0] period);
        longint c;
        longint p;
        longint span;
        p = period;
        span = shadow_cfg.match_tolerance;
        if (span > 0)
            span = span - 1;
        if (span > (64'sd1 << 20))
            span = 64'sd1 << 20;
        c = base;
        c = c + longint'($urandom_range(32'(2 * span))) - span;
        case ($urandom_range(3))
            0: c -= p;
            1: c += p;
            default: ;
        endcase
        if (c > COORD_MAX || c < COORD_MIN)
            c = base;
        return c[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord(logic [REG_W-1:0] period);
        longint c;
        longint p;
        p = period;
        case ($urandom_range(3))
            0: c = longint'($urandom());
            1: c = longint'($urandom_range(period));
            2: c = -longint'($urandom_range(period));
            default: begin
                case ($urandom_range(3))
                    0: c = COORD_MAX;
                    1: c = COORD_MIN;
                    2: c = p;
                    default: c = p + 1;
                endcase
            end
        endcase
        return c[COORD_W-1:0];
    endfunction

    function automatic pvdt_pkg::t_in_item make_vertex();
        pvdt_pkg::t_in_item vtx;
        pvdt_pkg::t_vertex  base;
        if (welded_table.size() != 0 && $urandom_range(99) < 65) begin
            base = welded_table[$urandom_range(welded_table.size() - 1)];
            vtx.coord_x = near_coord(base.x, shadow_cfg.period_x);
            vtx.coord_y = near_coord(base.y, shadow_cfg.period_y);
            vtx.coord_z = near_coord(base.z, shadow_cfg.period_z);
        end else begin
            vtx.coord_x = rand_coord(shadow_cfg.period_x);
            vtx.coord_y = rand_coord(shadow_cfg.period_y);
            vtx.coord_z = rand_coord(shadow_cfg.period_z);
        end
        return vtx;
    endfunction

    task automatic queue_vertex(pvdt_pkg::t_in_item vtx);
        while (pending_vertices.size() >= PENDING_MAX)
            @(posedge clk);
        pending_vertices.insert(pending_vertices.size(), vtx);
        items_queued++;
    endtask

    task automatic push_coords(longint x, longint y, longint z);
        pvdt_pkg::t_in_item vtx;
        vtx.coord_x = x[COORD_W-1:0];
        vtx.coord_y = y[COORD_W-1:0];
        vtx.coord_z = z[COORD_W-1:0];
        queue_vertex(vtx);
    endtask

    task automatic push_random(int count);
        repeat (count)
            queue_vertex(make_vertex());
    endtask

    task automatic wait_idle();
        while (items_checked != items_queued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_AW-1:0] addr, logic [REG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (addr)
            pvdt_pkg::CFG_PERIOD_X:  shadow_cfg.period_x = data;
            pvdt_pkg::CFG_PERIOD_Y:  shadow_cfg.period_y = data;
            pvdt_pkg::CFG_PERIOD_Z:  shadow_cfg.period_z = data;
            pvdt_pkg::CFG_MATCH_TOL: shadow_cfg.match_tolerance = data;
            default: ;
        endcase
    endtask

    task automatic write_settings(logic [REG_W-1:0] px, logic [REG_W-1:0] py,
                                  logic [REG_W-1:0] pz, logic [REG_W-1:0] tol);
        write_register(pvdt_pkg::CFG_PERIOD_X, px);
        write_register(pvdt_pkg::CFG_PERIOD_Y, py);
        write_register(pvdt_pkg::CFG_PERIOD_Z, pz);
        write_register(pvdt_pkg::CFG_MATCH_TOL, tol);
    endtask

    always @(posedge clk) begin : drive_vertices
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready)
                expected_welds.insert(expected_welds.size(), weld_vertex(in_item));
            if (!in_valid || in_ready) begin
                if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_item  <= pending_vertices.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check_welds
        pvdt_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                items_checked++;
                if (expected_welds.size() == 0) begin
                    $error("result item with no input waiting: %p", out_item);
                    error_count++;
                end else begin
                    want = expected_welds.pop_front();
                    if (out_item.unique_index !== want.unique_index) begin
                        $error("unique_index: expected %0d, got %0d",
                               want.unique_index, out_item.unique_index);
                        error_count++;
                    end
                    if (out_item.is_new !== want.is_new) begin
                        $error("is_new: expected %0d, got %0d", want.is_new, out_item.is_new);
                        error_count++;
                    end
                    if (out_item.table_overflow !== want.table_overflow) begin
                        $error("table_overflow: expected %0d, got %0d",
                               want.table_overflow, out_item.table_overflow);
                        error_count++;
                    end
                end
            end
            if (pressure_served != pressure_requests) begin
                hold_left = PRESSURE_HOLD;
                pressure_served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        longint p;
        longint t;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: welding at the tolerance edge and single folds
        p = pvdt_pkg::PERIOD_RESET;
        t = pvdt_pkg::TOL_RESET;
        push_coords(0, 0, 0);
        push_coords(0, 0, 0);
        push_coords(t - 1, t - 1, 0);
        push_coords(t, 0, 0);
        push_coords(0, t, 0);
        push_coords(p, p, p);
        push_coords(p + 1, p + 1, p + 1);
        push_coords(-1, -1, -1);
        push_coords(-p, -p, -p);
        push_coords(-p - 1, -p - 1, -p - 1);
        push_coords(2 * p + 3, 2 * p, 2 * p);
        push_coords(COORD_MAX, COORD_MIN, COORD_MAX);
        push_coords(COORD_MIN, COORD_MAX, COORD_MIN);
        push_coords(COORD_MAX, COORD_MIN, COORD_MAX);
        push_coords(64'hAAAA_AAAA, 64'h5555_5555, 64'hAAAA_AAAA);
        push_coords(64'h5555_5555, 64'hAAAA_AAAA, 64'h5555_5555);
        push_coords(p - t + 1, p, 1);
        push_coords(1, t - 1, p);
        wait_idle();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_settings(REG_W'(1 << 24), REG_W'(3 << 22), REG_W'(1 << 23), REG_W'(1 << 16));
        write_register(CFG_SPARE, REG_W'($urandom()));
        push_random(120);
        wait_idle();

        // extreme periods, zero period on z, widest tolerance
        send_idle_pct = 61;
        write_settings(REG_W'(1), REG_W'(32'h7FFF_FFFF), REG_W'(0), REG_W'(32'h7FFF_FFFF));
        push_random(60);
        wait_idle();

        // zero tolerance, every item becomes a new entry
        send_idle_pct = 0;
        recv_stall_pct = 61;
        write_settings(pvdt_pkg::PERIOD_RESET, pvdt_pkg::PERIOD_RESET,
                       REG_W'(32'h7FFF_FFFF), REG_W'(0));
        push_random(170);
        wait_idle();

        recv_stall_pct = 0;
        write_settings(REG_W'($urandom_range(1, 32'h7FFF_FFFF)), pvdt_pkg::PERIOD_RESET,
                       REG_W'($urandom_range(1, 1 << 26)), REG_W'($urandom_range(1, 1 << 24)));
        pressure_requests++;
        push_random(90);
        wait_idle();

        send_idle_pct = 24;
        recv_stall_pct = 24;
        write_settings(REG_W'($urandom_range(1 << 20, 1 << 26)),
                       REG_W'($urandom_range(1, 1 << 24)),
                       pvdt_pkg::PERIOD_RESET, REG_W'($urandom_range(1, 1 << 22)));
        push_random(120);

        while (items_checked != items_queued)
            @(posedge clk);
        repeat (TABLE_SIZE + SETTLE_CYCLES) @(posedge clk);
        if (expected_welds.size() != 0)
            $error("%0d expected result items never arrived", expected_welds.size());
        if (error_count == 0 && expected_welds.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- periodic_vertex_dedup_table_core.f -----
sv/pvdt_pkg.sv
sv/pvdt_ram.sv
sv/pvdt_front.sv
sv/pvdt_queue.sv
sv/pvdt_back.sv
sv/periodic_vertex_dedup_table_core.sv
sim/tb_periodic_vertex_dedup_table_core.sv
